// ===== rtl/box_blur_3x3_rgb_top_defines.svh =====
// Assertion helpers for the box blur block.
// Each macro samples on clk_i and is off while rst_ni is low.
`ifndef BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH

// Condition holds at every edge.
`define BB3_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BB3_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BB3_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bb3x3_pkg.sv =====
`default_nettype none

package bb3x3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Frame geometry
  localparam int DIM_W  = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);

  // Row memory: three rows of MAX_WIDTH pixels
  localparam int MEM_DEPTH = 3 * MAX_WIDTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Pixel and arithmetic widths
  localparam int NUM_CH = 3;
  localparam int CH_W   = 8;
  localparam int PIX_W  = NUM_CH * CH_W;
  localparam int SUM_W  = $clog2(9 * 255 + 1);
  localparam int NUM_W  = $clog2(2 * 9 * 255 + 9 + 1);
  localparam int CNT_W  = 4;
  localparam int DEN_W  = CNT_W + 1;
  localparam int QBIT_W = $clog2(CH_W);

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Neighborhood offsets along one axis
  localparam logic [1:0] TAP_PREV = 2'd0;
  localparam logic [1:0] TAP_SAME = 2'd1;
  localparam logic [1:0] TAP_NEXT = 2'd2;

  // Row slot in the memory, row index modulo three
  localparam logic [1:0] SLOT_FIRST = 2'd0;
  localparam logic [1:0] SLOT_LAST  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_ACC,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/box_blur_3x3_rgb_top.sv =====
// An item enters ST_CHECK, then ST_IDLE if no result is ready, else nine serial tap reads
//   (ST_READ), ST_ACC, ST_PREP, an 8-step divider (ST_DIV) and ST_OUT, held by out_stall_i.
//   in_stall_o is high outside ST_IDLE, so no item is taken before the last is through.
// A pixel is written to the row memory at its own transfer edge.
// Reset: frame position and done flag clear, width and height go to 1024.
//   The row memory is not cleared; no pixel is read before it is written.
`default_nettype none

`include "box_blur_3x3_rgb_top_defines.svh"

module box_blur_3x3_rgb_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [bb3x3_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bb3x3_pkg::DIM_W-1:0]        cfg_data_i,
  // item input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic [bb3x3_pkg::CH_W-1:0]         in_red_i,
  input  logic [bb3x3_pkg::CH_W-1:0]         in_green_i,
  input  logic [bb3x3_pkg::CH_W-1:0]         in_blue_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bb3x3_pkg::CH_W-1:0]         out_red_o,
  output logic [bb3x3_pkg::CH_W-1:0]         out_green_o,
  output logic [bb3x3_pkg::CH_W-1:0]         out_blue_o,
  output logic                               last_of_frame_o
);

  bb3x3_pkg::state_e state_q, state_d;

  logic [bb3x3_pkg::DIM_W-1:0] width_q, width_d, height_q, height_d;
  logic [bb3x3_pkg::DIM_W-1:0] w_eff, h_eff;
  logic [bb3x3_pkg::COL_W-1:0] w_m1;
  logic [bb3x3_pkg::ROW_W-1:0] h_m1;

  logic [bb3x3_pkg::ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [bb3x3_pkg::COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [1:0]                  in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic                        frame_done_q, frame_done_d;

  logic [1:0] tap_r_q, tap_r_d, tap_c_q, tap_c_d;
  logic       rd_vld_q, rd_vld_d;

  logic [bb3x3_pkg::SUM_W-1:0]  sum_q [bb3x3_pkg::NUM_CH];
  logic [bb3x3_pkg::SUM_W-1:0]  sum_d [bb3x3_pkg::NUM_CH];
  logic [bb3x3_pkg::NUM_W-1:0]  rem_q [bb3x3_pkg::NUM_CH];
  logic [bb3x3_pkg::NUM_W-1:0]  rem_d [bb3x3_pkg::NUM_CH];
  logic [bb3x3_pkg::CH_W-1:0]   quo_q [bb3x3_pkg::NUM_CH];
  logic [bb3x3_pkg::CH_W-1:0]   quo_d [bb3x3_pkg::NUM_CH];
  logic [bb3x3_pkg::CH_W-1:0]   res_q [bb3x3_pkg::NUM_CH];
  logic [bb3x3_pkg::CH_W-1:0]   res_d [bb3x3_pkg::NUM_CH];
  logic [bb3x3_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [bb3x3_pkg::DEN_W-1:0]  den_q, den_d;
  logic [bb3x3_pkg::QBIT_W-1:0] div_bit_q, div_bit_d;
  logic [bb3x3_pkg::NUM_W-1:0]  den_sh;

  logic out_valid_q, out_valid_d, out_last_q, out_last_d;

  logic                         in_acc, wr_en, rd_en, ready, out_load, out_last_pos;
  logic [bb3x3_pkg::ROW_W-1:0]  need_row;
  logic [bb3x3_pkg::COL_W-1:0]  need_col;
  logic                         row_ok, col_ok, tap_ok;
  logic [1:0]                   tap_slot;
  logic [bb3x3_pkg::COL_W-1:0]  tap_col;
  logic [bb3x3_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [bb3x3_pkg::PIX_W-1:0]  rd_data_q;
  logic                         cnt_legal, restarted, st_out;

  logic [bb3x3_pkg::PIX_W-1:0]  row_mem [bb3x3_pkg::MEM_DEPTH];

  // Geometry: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (width_q == '0) begin
      w_eff = bb3x3_pkg::DIM_W'(1);
    end else if (width_q > bb3x3_pkg::DIM_W'(bb3x3_pkg::MAX_WIDTH)) begin
      w_eff = bb3x3_pkg::DIM_W'(bb3x3_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = bb3x3_pkg::DIM_W'(1);
    end else if (height_q > bb3x3_pkg::DIM_W'(bb3x3_pkg::MAX_HEIGHT)) begin
      h_eff = bb3x3_pkg::DIM_W'(bb3x3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
    w_m1 = bb3x3_pkg::COL_W'(w_eff - bb3x3_pkg::DIM_W'(1));
    h_m1 = bb3x3_pkg::ROW_W'(h_eff - bb3x3_pkg::DIM_W'(1));
  end

  assign in_stall_o   = (state_q != bb3x3_pkg::ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign wr_en        = in_acc && (opcode_i == bb3x3_pkg::OP_PIXEL) && !frame_done_q;
  assign out_load     = (state_q == bb3x3_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);
  assign out_last_pos = (out_row_q == h_m1) && (out_col_q == w_m1);

  // A result is ready once the bottom-right neighbor of the output pixel has arrived
  assign need_row = (out_row_q == h_m1) ? out_row_q : out_row_q + bb3x3_pkg::ROW_W'(1);
  assign need_col = (out_col_q == w_m1) ? out_col_q : out_col_q + bb3x3_pkg::COL_W'(1);
  assign ready    = frame_done_q || (in_row_q > need_row) ||
                    ((in_row_q == need_row) && (in_col_q > need_col));

  // Tap address for the current neighbor
  always_comb begin
    case (tap_r_q)
      bb3x3_pkg::TAP_PREV: begin
        row_ok   = (out_row_q != '0);
        tap_slot = (out_slot_q == bb3x3_pkg::SLOT_FIRST) ? bb3x3_pkg::SLOT_LAST
                                                         : out_slot_q - 2'd1;
      end
      bb3x3_pkg::TAP_SAME: begin
        row_ok   = 1'b1;
        tap_slot = out_slot_q;
      end
      bb3x3_pkg::TAP_NEXT: begin
        row_ok   = (out_row_q != h_m1);
        tap_slot = (out_slot_q == bb3x3_pkg::SLOT_LAST) ? bb3x3_pkg::SLOT_FIRST
                                                        : out_slot_q + 2'd1;
      end
      default: begin
        row_ok   = 1'b0;
        tap_slot = out_slot_q;
      end
    endcase
    case (tap_c_q)
      bb3x3_pkg::TAP_PREV: begin
        col_ok  = (out_col_q != '0);
        tap_col = out_col_q - bb3x3_pkg::COL_W'(1);
      end
      bb3x3_pkg::TAP_SAME: begin
        col_ok  = 1'b1;
        tap_col = out_col_q;
      end
      bb3x3_pkg::TAP_NEXT: begin
        col_ok  = (out_col_q != w_m1);
        tap_col = out_col_q + bb3x3_pkg::COL_W'(1);
      end
      default: begin
        col_ok  = 1'b0;
        tap_col = out_col_q;
      end
    endcase
  end

  assign tap_ok  = row_ok && col_ok;
  assign rd_en   = (state_q == bb3x3_pkg::ST_READ) && tap_ok;
  assign rd_addr = bb3x3_pkg::ADDR_W'(tap_slot) * bb3x3_pkg::ADDR_W'(bb3x3_pkg::MAX_WIDTH)
                 + bb3x3_pkg::ADDR_W'(tap_col);
  assign wr_addr = bb3x3_pkg::ADDR_W'(in_slot_q) * bb3x3_pkg::ADDR_W'(bb3x3_pkg::MAX_WIDTH)
                 + bb3x3_pkg::ADDR_W'(in_col_q);
  assign den_sh  = bb3x3_pkg::NUM_W'(den_q) << div_bit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem[wr_addr] <= {in_red_i, in_green_i, in_blue_i};
    end
    if (rd_en) begin
      rd_data_q <= row_mem[rd_addr];
    end
  end

  always_comb begin : next_state
    state_d = state_q;
    case (state_q)
      bb3x3_pkg::ST_IDLE:  if (in_acc) state_d = bb3x3_pkg::ST_CHECK;
      bb3x3_pkg::ST_CHECK: state_d = ready ? bb3x3_pkg::ST_READ : bb3x3_pkg::ST_IDLE;
      bb3x3_pkg::ST_READ: begin
        if (tap_r_q == bb3x3_pkg::TAP_NEXT && tap_c_q == bb3x3_pkg::TAP_NEXT) begin
          state_d = bb3x3_pkg::ST_ACC;
        end
      end
      bb3x3_pkg::ST_ACC:   state_d = bb3x3_pkg::ST_PREP;
      bb3x3_pkg::ST_PREP:  state_d = bb3x3_pkg::ST_DIV;
      bb3x3_pkg::ST_DIV:   if (div_bit_q == '0) state_d = bb3x3_pkg::ST_OUT;
      bb3x3_pkg::ST_OUT:   if (out_load) state_d = bb3x3_pkg::ST_IDLE;
      default:             state_d = bb3x3_pkg::ST_IDLE;
    endcase
  end

  always_comb begin : datapath
    logic ge;
    width_d      = width_q;
    height_d     = height_q;
    in_row_d     = in_row_q;
    in_col_d     = in_col_q;
    in_slot_d    = in_slot_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_slot_d   = out_slot_q;
    frame_done_d = frame_done_q;
    tap_r_d      = tap_r_q;
    tap_c_d      = tap_c_q;
    cnt_d        = cnt_q;
    den_d        = den_q;
    div_bit_d    = div_bit_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_last_d   = out_last_q;
    rd_vld_d     = rd_en;
    ge           = 1'b0;
    for (int ch = 0; ch < bb3x3_pkg::NUM_CH; ch++) begin
      sum_d[ch] = sum_q[ch];
      rem_d[ch] = rem_q[ch];
      quo_d[ch] = quo_q[ch];
      res_d[ch] = res_q[ch];
    end

    // Any register write restarts the frame
    if (cfg_we_i) begin
      case (cfg_index_i)
        bb3x3_pkg::REG_WIDTH:  width_d  = cfg_data_i;
        bb3x3_pkg::REG_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
      in_row_d     = '0;
      in_col_d     = '0;
      in_slot_d    = bb3x3_pkg::SLOT_FIRST;
      out_row_d    = '0;
      out_col_d    = '0;
      out_slot_d   = bb3x3_pkg::SLOT_FIRST;
      frame_done_d = 1'b0;
    end

    // Advance the input position
    if (wr_en) begin
      if (in_row_q == h_m1 && in_col_q == w_m1) begin
        frame_done_d = 1'b1;
      end else if (in_col_q == w_m1) begin
        in_col_d  = '0;
        in_row_d  = in_row_q + bb3x3_pkg::ROW_W'(1);
        in_slot_d = (in_slot_q == bb3x3_pkg::SLOT_LAST) ? bb3x3_pkg::SLOT_FIRST
                                                        : in_slot_q + 2'd1;
      end else begin
        in_col_d = in_col_q + bb3x3_pkg::COL_W'(1);
      end
    end

    if (state_q == bb3x3_pkg::ST_CHECK) begin
      tap_r_d = bb3x3_pkg::TAP_PREV;
      tap_c_d = bb3x3_pkg::TAP_PREV;
      cnt_d   = '0;
      for (int ch = 0; ch < bb3x3_pkg::NUM_CH; ch++) begin
        sum_d[ch] = '0;
      end
    end

    if (state_q == bb3x3_pkg::ST_READ) begin
      if (tap_c_q == bb3x3_pkg::TAP_NEXT) begin
        tap_c_d = bb3x3_pkg::TAP_PREV;
        tap_r_d = tap_r_q + 2'd1;
      end else begin
        tap_c_d = tap_c_q + 2'd1;
      end
    end

    // Read data arrives in the cycle after its address
    if (rd_vld_q) begin
      cnt_d = cnt_q + bb3x3_pkg::CNT_W'(1);
      for (int ch = 0; ch < bb3x3_pkg::NUM_CH; ch++) begin
        sum_d[ch] = sum_q[ch] + bb3x3_pkg::SUM_W'(
          rd_data_q[bb3x3_pkg::PIX_W - bb3x3_pkg::CH_W * (ch + 1) +: bb3x3_pkg::CH_W]);
      end
    end

    // Half-up rounding: (2*sum + cnt) / (2*cnt)
    if (state_q == bb3x3_pkg::ST_PREP) begin
      den_d     = {cnt_q, 1'b0};
      div_bit_d = bb3x3_pkg::QBIT_W'(bb3x3_pkg::CH_W - 1);
      for (int ch = 0; ch < bb3x3_pkg::NUM_CH; ch++) begin
        rem_d[ch] = {sum_q[ch], 1'b0} + bb3x3_pkg::NUM_W'(cnt_q);
        quo_d[ch] = '0;
      end
    end

    // One quotient bit per cycle, most significant first
    if (state_q == bb3x3_pkg::ST_DIV) begin
      div_bit_d = div_bit_q - bb3x3_pkg::QBIT_W'(1);
      for (int ch = 0; ch < bb3x3_pkg::NUM_CH; ch++) begin
        ge = (rem_q[ch] >= den_sh);
        if (ge) begin
          rem_d[ch] = rem_q[ch] - den_sh;
        end
        quo_d[ch][div_bit_q] = ge;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      out_last_d  = out_last_pos;
      for (int ch = 0; ch < bb3x3_pkg::NUM_CH; ch++) begin
        res_d[ch] = quo_q[ch];
      end
      if (out_last_pos) begin
        in_row_d     = '0;
        in_col_d     = '0;
        in_slot_d    = bb3x3_pkg::SLOT_FIRST;
        out_row_d    = '0;
        out_col_d    = '0;
        out_slot_d   = bb3x3_pkg::SLOT_FIRST;
        frame_done_d = 1'b0;
      end else if (out_col_q == w_m1) begin
        out_col_d  = '0;
        out_row_d  = out_row_q + bb3x3_pkg::ROW_W'(1);
        out_slot_d = (out_slot_q == bb3x3_pkg::SLOT_LAST) ? bb3x3_pkg::SLOT_FIRST
                                                          : out_slot_q + 2'd1;
      end else begin
        out_col_d = out_col_q + bb3x3_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bb3x3_pkg::ST_IDLE;
      width_q      <= bb3x3_pkg::DIM_W'(bb3x3_pkg::MAX_WIDTH);
      height_q     <= bb3x3_pkg::DIM_W'(bb3x3_pkg::MAX_HEIGHT);
      in_row_q     <= '0;
      in_col_q     <= '0;
      in_slot_q    <= bb3x3_pkg::SLOT_FIRST;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_slot_q   <= bb3x3_pkg::SLOT_FIRST;
      frame_done_q <= 1'b0;
      tap_r_q      <= bb3x3_pkg::TAP_PREV;
      tap_c_q      <= bb3x3_pkg::TAP_PREV;
      rd_vld_q     <= 1'b0;
      div_bit_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      width_q      <= width_d;
      height_q     <= height_d;
      in_row_q     <= in_row_d;
      in_col_q     <= in_col_d;
      in_slot_q    <= in_slot_d;
      out_row_q    <= out_row_d;
      out_col_q    <= out_col_d;
      out_slot_q   <= out_slot_d;
      frame_done_q <= frame_done_d;
      tap_r_q      <= tap_r_d;
      tap_c_q      <= tap_c_d;
      rd_vld_q     <= rd_vld_d;
      div_bit_q    <= div_bit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    den_q      <= den_d;
    out_last_q <= out_last_d;
    for (int ch = 0; ch < bb3x3_pkg::NUM_CH; ch++) begin
      sum_q[ch] <= sum_d[ch];
      rem_q[ch] <= rem_d[ch];
      quo_q[ch] <= quo_d[ch];
      res_q[ch] <= res_d[ch];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_red_o       = res_q[0];
  assign out_green_o     = res_q[1];
  assign out_blue_o      = res_q[2];
  assign last_of_frame_o = out_last_q;

  assign cnt_legal = (cnt_q == 4'd1) || (cnt_q == 4'd2) || (cnt_q == 4'd3) ||
                     (cnt_q == 4'd4) || (cnt_q == 4'd6) || (cnt_q == 4'd9);
  assign restarted = (out_row_q == '0) && (out_col_q == '0) && (in_row_q == '0) &&
                     !frame_done_q && out_last_q;
  assign st_out    = (state_q == bb3x3_pkg::ST_OUT);

  `BB3_ASSERT_NOW(a_pos_in_frame, (in_row_q <= h_m1) && (out_row_q <= h_m1), "position outside frame")
  `BB3_ASSERT_IMP(a_div_count, state_q == bb3x3_pkg::ST_PREP, cnt_legal, "bad neighbor count")
  `BB3_ASSERT_NXT(a_end_clear, out_load && out_last_pos, restarted, "frame end did not restart")
  `BB3_ASSERT_IMP(a_result_source, $rose(out_valid_o), $past(st_out), "result without divide")

endmodule

`default_nettype wire
